>>> rtl/core/brfifo_pkg.sv
// ----------------------------------------------------------------------------
// brfifo_pkg
// Shared sizes, codes and helpers for the burst ring FIFO.
// ----------------------------------------------------------------------------
package brfifo_pkg;

    localparam int DEPTH      = 64;
    localparam int ELEM_BYTES = 4;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] ELEM_MASK =
        (ELEM_BYTES >= 4) ? {DATA_W{1'b1}}
                          : DATA_W'((64'd1 << (8 * ELEM_BYTES)) - 64'd1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    function automatic logic [CNT_W-1:0] used_of(input logic [CNT_W-1:0] wc,
                                                 input logic [CNT_W-1:0] rc);
        used_of = wc - rc;
    endfunction

    function automatic logic [CNT_W-1:0] free_of(input logic [CNT_W-1:0] used);
        free_of = (used <= DEPTH_CNT) ? (DEPTH_CNT - used) : '0;
    endfunction

endpackage

>>> rtl/core/burst_ring_fifo.sv
// ----------------------------------------------------------------------------
// burst_ring_fifo
// Ring FIFO with all-or-nothing put bursts and counted get requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): op, burst_count, put_data. A put burst
// is a run of put beats; its first beat decides from the free space whether
// the whole burst is stored or refused. A get beat asks for burst_count
// elements and yields that many result beats (one for zero), or one refusal.
// Output channel (out_valid/out_ready): one result beat per put beat, one per
// popped element, last set on the final beat of each input beat, with the
// used and free counts and the empty flag after that beat.
// A put or refused get shows its result in the cycle after it is taken;
// a put beat is taken every cycle while the output drains. An accepted get
// enters the get state, reads its elements from the RAM in turn and gives
// one beat per cycle while the receiver takes them (the RAM read port is
// pipelined one ahead); no new input is taken until its last beat is out.
// Reset clears the counters and burst state; the element RAM is not cleared.
// When the receiver stalls, the output register holds its beat, no new input
// is taken and the RAM read stream pauses with the pending word held.
// ----------------------------------------------------------------------------
module burst_ring_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [brfifo_pkg::CNT_W-1:0]     burst_count,
    input  logic [brfifo_pkg::DATA_W-1:0]    put_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ok,
    output logic [brfifo_pkg::DATA_W-1:0]    get_data,
    output logic                             last,
    output logic [brfifo_pkg::CNT_W-1:0]     used_count,
    output logic [brfifo_pkg::CNT_W-1:0]     free_count,
    output logic                             is_empty
);

    typedef enum logic {ST_IDLE, ST_GET} state_t;

    state_t                          state_reg, state_next;
    logic [brfifo_pkg::CNT_W-1:0]    wcnt_reg, wcnt_next;
    logic [brfifo_pkg::CNT_W-1:0]    rcnt_reg, rcnt_next;
    logic [brfifo_pkg::CNT_W-1:0]    burst_rem_reg, burst_rem_next;
    logic                            burst_acc_reg, burst_acc_next;
    logic [brfifo_pkg::CNT_W-1:0]    issue_left_reg, issue_left_next;
    logic [brfifo_pkg::CNT_W-1:0]    out_left_reg, out_left_next;
    logic [brfifo_pkg::IDX_W-1:0]    rd_addr_reg, rd_addr_next;
    logic                            rd_pend_reg, rd_pend_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            ok_reg, ok_next;
    logic [brfifo_pkg::DATA_W-1:0]   data_reg, data_next;
    logic                            last_reg, last_next;
    logic [brfifo_pkg::CNT_W-1:0]    used_reg, used_next;
    logic [brfifo_pkg::CNT_W-1:0]    free_reg, free_next;
    logic                            empty_reg, empty_next;

    logic                            ram_we;
    logic                            ram_re;
    logic [brfifo_pkg::DATA_W-1:0]   ram_rdata;

    logic                            out_free;
    logic                            in_fire;
    logic                            consume;
    logic                            issue;
    logic [brfifo_pkg::CNT_W-1:0]    used_now;
    logic [brfifo_pkg::CNT_W-1:0]    put_n;
    logic [brfifo_pkg::CNT_W-1:0]    put_rem;
    logic                            put_acc;
    logic [brfifo_pkg::CNT_W-1:0]    used_after;

    brfifo_ram #(
        .WIDTH (brfifo_pkg::DATA_W),
        .DEPTH (brfifo_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wcnt_reg[brfifo_pkg::IDX_W-1:0]),
        .wr_data (put_data & brfifo_pkg::ELEM_MASK),
        .rd_en   (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign used_now = brfifo_pkg::used_of(wcnt_reg, rcnt_reg);
    assign put_n    = (burst_count == '0) ? brfifo_pkg::CNT_W'(1) : burst_count;
    assign put_acc  = (burst_rem_reg == '0) ? (brfifo_pkg::free_of(used_now) >= put_n)
                                            : burst_acc_reg;
    assign put_rem  = (burst_rem_reg == '0) ? put_n : burst_rem_reg;
    assign consume  = (state_reg == ST_GET) && rd_pend_reg && out_free;
    assign issue    = (state_reg == ST_GET) && (issue_left_reg != '0)
                      && (!rd_pend_reg || consume);

    always_comb
    begin
        state_next      = state_reg;
        wcnt_next       = wcnt_reg;
        rcnt_next       = rcnt_reg;
        burst_rem_next  = burst_rem_reg;
        burst_acc_next  = burst_acc_reg;
        issue_left_next = issue_left_reg;
        out_left_next   = out_left_reg;
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ok_next         = ok_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        empty_next      = empty_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        used_after      = used_now;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    data_next      = '0;
                    last_next      = 1'b1;
                    if (op == brfifo_pkg::OP_PUT)
                    begin
                        burst_acc_next = put_acc;
                        burst_rem_next = put_rem - brfifo_pkg::CNT_W'(1);
                        ok_next        = put_acc;
                        if (put_acc)
                        begin
                            ram_we     = 1'b1;
                            wcnt_next  = wcnt_reg + brfifo_pkg::CNT_W'(1);
                            used_after = used_now + brfifo_pkg::CNT_W'(1);
                        end
                    end
                    else if ((burst_rem_reg != '0) || (used_now < burst_count))
                    begin
                        ok_next = 1'b0;
                    end
                    else if (burst_count == '0)
                    begin
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next  = 1'b0;
                        state_next      = ST_GET;
                        issue_left_next = burst_count;
                        out_left_next   = burst_count;
                        rd_addr_next    = rcnt_reg[brfifo_pkg::IDX_W-1:0];
                        rd_pend_next    = 1'b0;
                    end
                    used_next  = used_after;
                    free_next  = brfifo_pkg::free_of(used_after);
                    empty_next = (used_after == '0);
                end
            end
            ST_GET:
            begin
                if (issue)
                begin
                    ram_re          = 1'b1;
                    rd_addr_next    = rd_addr_reg + brfifo_pkg::IDX_W'(1);
                    issue_left_next = issue_left_reg - brfifo_pkg::CNT_W'(1);
                    rd_pend_next    = 1'b1;
                end
                else if (consume)
                begin
                    rd_pend_next = 1'b0;
                end
                if (consume)
                begin
                    used_after     = used_now - brfifo_pkg::CNT_W'(1);
                    rcnt_next      = rcnt_reg + brfifo_pkg::CNT_W'(1);
                    out_left_next  = out_left_reg - brfifo_pkg::CNT_W'(1);
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    data_next      = ram_rdata;
                    last_next      = (out_left_reg == brfifo_pkg::CNT_W'(1));
                    used_next      = used_after;
                    free_next      = brfifo_pkg::free_of(used_after);
                    empty_next     = (used_after == '0);
                    if (out_left_reg == brfifo_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wcnt_reg       <= '0;
            rcnt_reg       <= '0;
            burst_rem_reg  <= '0;
            burst_acc_reg  <= 1'b0;
            issue_left_reg <= '0;
            out_left_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wcnt_reg       <= wcnt_next;
            rcnt_reg       <= rcnt_next;
            burst_rem_reg  <= burst_rem_next;
            burst_acc_reg  <= burst_acc_next;
            issue_left_reg <= issue_left_next;
            out_left_reg   <= out_left_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        ok_reg      <= ok_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
        used_reg    <= used_next;
        free_reg    <= free_next;
        empty_reg   <= empty_next;
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign get_data   = data_reg;
    assign last       = last_reg;
    assign used_count = used_reg;
    assign free_count = free_reg;
    assign is_empty   = empty_reg;

endmodule

>>> rtl/core/brfifo_ram.sv
// ----------------------------------------------------------------------------
// brfifo_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module brfifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/brfifo_checker.sv
// ----------------------------------------------------------------------------
// brfifo_checker
// Port-level checks for the burst ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module brfifo_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             op,
    input  logic [brfifo_pkg::CNT_W-1:0]     burst_count,
    input  logic [brfifo_pkg::DATA_W-1:0]    put_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             ok,
    input  logic [brfifo_pkg::DATA_W-1:0]    get_data,
    input  logic                             last,
    input  logic [brfifo_pkg::CNT_W-1:0]     used_count,
    input  logic [brfifo_pkg::CNT_W-1:0]     free_count,
    input  logic                             is_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(get_data) && $stable(ok)
                                    && $stable(last) && $stable(used_count))
        else $error("result beat changed while stalled");

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_count + free_count) == brfifo_pkg::DEPTH_CNT)
        else $error("used and free counts do not add up to depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_empty == (used_count == '0))
        else $error("empty flag disagrees with used count");

    a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> last && (get_data == '0))
        else $error("refusal beat carries data or is not last");

    a_put_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == brfifo_pkg::OP_PUT) |=> out_valid && last
                                                             && (get_data == '0))
        else $error("put beat did not give a single result beat");

endmodule

bind burst_ring_fifo brfifo_checker u_brfifo_checker (.*);

>>> tb/burst_ring_fifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burst_ring_fifo_checker
// Watches both channels of the burst ring FIFO, predicts every result beat
// from the accepted input beats and compares them field by field.
// ----------------------------------------------------------------------------
module burst_ring_fifo_checker
    import brfifo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              op,
    input  logic [CNT_W-1:0]  burst_count,
    input  logic [DATA_W-1:0] put_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              ok,
    input  logic [DATA_W-1:0] get_data,
    input  logic              last,
    input  logic [CNT_W-1:0]  used_count,
    input  logic [CNT_W-1:0]  free_count,
    input  logic              is_empty,
    output int                fail_count,
    output int                pending_results,
    output int                results_checked
);

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free;
        logic              empty;
    } fifo_result_t;

    fifo_result_t      due_results[$];
    logic [DATA_W-1:0] slots[DEPTH];
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  burst_left;
    logic              burst_ok;
    int                mismatches;
    int                n_checked;

    function automatic logic [CNT_W-1:0] occupancy();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic logic [CNT_W-1:0] vacancy();
        logic [CNT_W-1:0] u;
        u = occupancy();
        return (u <= DEPTH) ? CNT_W'(DEPTH - u) : '0;
    endfunction

    function automatic fifo_result_t status_beat(input logic okv,
                                                 input logic [DATA_W-1:0] d,
                                                 input logic lastv);
        fifo_result_t r;
        r.ok    = okv;
        r.data  = d;
        r.last  = lastv;
        r.used  = occupancy();
        r.free  = vacancy();
        r.empty = (wr_ptr == rd_ptr);
        return r;
    endfunction

    task automatic apply_beat(input logic o, input logic [CNT_W-1:0] c,
                              input logic [DATA_W-1:0] d);
        logic [CNT_W-1:0]  n;
        logic [DATA_W-1:0] v;
        int                k;
        if (o == OP_PUT)
        begin
            if (burst_left == 0)
            begin
                n          = (c == 0) ? CNT_W'(1) : c;
                burst_ok   = (vacancy() >= n);
                burst_left = n;
            end
            if (burst_ok)
            begin
                slots[wr_ptr[IDX_W-1:0]] = d & ELEM_MASK;
                wr_ptr = wr_ptr + CNT_W'(1);
            end
            burst_left = burst_left - CNT_W'(1);
            due_results.push_back(status_beat(burst_ok, '0, 1'b1));
        end
        else if (burst_left != 0 || occupancy() < c)
            due_results.push_back(status_beat(1'b0, '0, 1'b1));
        else if (c == 0)
            due_results.push_back(status_beat(1'b1, '0, 1'b1));
        else
        begin
            for (k = 0; k < int'(c); k++)
            begin
                v      = slots[rd_ptr[IDX_W-1:0]];
                rd_ptr = rd_ptr + CNT_W'(1);
                due_results.push_back(status_beat(1'b1, v, k == int'(c) - 1));
            end
        end
    endtask

    function automatic int field_bad(input string name, input logic [DATA_W-1:0] want,
                                     input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        fifo_result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            wr_ptr          = '0;
            rd_ptr          = '0;
            burst_left      = '0;
            burst_ok        = 1'b0;
            mismatches      = 0;
            n_checked       = 0;
            fail_count      <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_beat(op, burst_count, put_data);
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    mismatches += field_bad("ok", DATA_W'(want.ok), DATA_W'(ok));
                    mismatches += field_bad("get_data", want.data, get_data);
                    mismatches += field_bad("last", DATA_W'(want.last), DATA_W'(last));
                    mismatches += field_bad("used_count", DATA_W'(want.used),
                                            DATA_W'(used_count));
                    mismatches += field_bad("free_count", DATA_W'(want.free),
                                            DATA_W'(free_count));
                    mismatches += field_bad("is_empty", DATA_W'(want.empty),
                                            DATA_W'(is_empty));
                    n_checked++;
                end
            end
            fail_count      <= mismatches;
            pending_results <= due_results.size();
            results_checked <= n_checked;
        end
    end

endmodule

>>> tb/burst_ring_fifo_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burst_ring_fifo_tb
// Drives put bursts and get requests into the burst ring FIFO under varying
// sender and receiver idling, including a long receiver stall that fills the
// FIFO, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module burst_ring_fifo_tb;
    import brfifo_pkg::*;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              op          = OP_PUT;
    logic [CNT_W-1:0]  burst_count = '0;
    logic [DATA_W-1:0] put_data    = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              ok;
    logic [DATA_W-1:0] get_data;
    logic              last;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic              is_empty;

    int   fail_count;
    int   pending_results;
    int   results_checked;

    int   send_idle  = 0;
    int   recv_idle  = 0;
    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    int   level      = 0;
    int   peak_level = 0;
    int   beats_sent = 0;
    int   puts_sent  = 0;
    int   gets_sent  = 0;

    burst_ring_fifo uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .burst_count (burst_count),
        .put_data    (put_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .get_data    (get_data),
        .last        (last),
        .used_count  (used_count),
        .free_count  (free_count),
        .is_empty    (is_empty)
    );

    burst_ring_fifo_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .burst_count     (burst_count),
        .put_data        (put_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .get_data        (get_data),
        .last            (last),
        .used_count      (used_count),
        .free_count      (free_count),
        .is_empty        (is_empty),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 200;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_beat(input logic o, input logic [CNT_W-1:0] c,
                             input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        burst_count <= c;
        put_data    <= d;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        if (o == OP_PUT)
            puts_sent++;
        else
            gets_sent++;
    endtask

    task automatic put_burst(input int count_field, input bit may_break);
        int n;
        int k;
        int brk;
        n   = (count_field == 0) ? 1 : count_field;
        brk = (may_break && n > 1 && $urandom_range(99) < 15) ? $urandom_range(1, n - 1) : 0;
        if (DEPTH - level >= n)
            level += n;
        if (level > peak_level)
            peak_level = level;
        for (k = 0; k < n; k++)
        begin
            if (brk != 0 && k == brk)
                send_beat(OP_GET, CNT_W'($urandom_range(0, 8)), $urandom);
            send_beat(OP_PUT, (k == 0) ? CNT_W'(count_field) : CNT_W'($urandom_range(0, 64)),
                      $urandom);
        end
    endtask

    task automatic get_req(input int c);
        if (c <= level)
            level -= c;
        send_beat(OP_GET, CNT_W'(c), $urandom);
    endtask

    task automatic random_beats(input int target);
        int start;
        int r;
        start = beats_sent;
        while (beats_sent - start < target)
        begin
            r = $urandom_range(99);
            if ($urandom_range(99) < ((level < 16) ? 65 : 40))
            begin
                if (r < 15)
                    put_burst(0, 1);
                else if (r < 65)
                    put_burst($urandom_range(1, 8), 1);
                else if (r < 90)
                    put_burst($urandom_range(9, 24), 1);
                else
                    put_burst($urandom_range(25, 64), 1);
            end
            else if (r < 10)
                get_req(0);
            else if (r < 80 && level > 0)
                get_req($urandom_range(1, level));
            else
                get_req($urandom_range(1, 64));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty corner cases, count of zero, break-in get, sizes
        send_idle <= 6;
        recv_idle <= 54;
        get_req(0);
        get_req(1);
        get_req(64);
        send_beat(OP_PUT, CNT_W'(0), 32'hFFFF_FFFF);
        level += 1;
        send_beat(OP_PUT, CNT_W'(3), 32'h0000_0000);
        send_beat(OP_PUT, CNT_W'(64), 32'hA5A5_A5A5);
        send_beat(OP_PUT, CNT_W'(0), 32'h5A5A_5A5A);
        level += 3;
        send_beat(OP_PUT, CNT_W'(2), 32'h8000_0001);
        send_beat(OP_GET, CNT_W'(1), 32'h0);
        send_beat(OP_PUT, CNT_W'(1), 32'h7FFF_FFFE);
        level += 2;
        get_req(7);
        get_req(0);
        get_req(6);

        random_beats(10);

        send_idle <= 54;
        recv_idle <= 6;
        random_beats(10);

        // no idling; fill to full behind a long receiver stall
        send_idle <= 0;
        recv_idle <= 0;
        if (level > 0)
            get_req(level);
        hold_req <= ~hold_req;
        put_burst(64, 0);
        put_burst(1, 0);
        get_req(64);
        random_beats(10);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d input beats (%0d put, %0d get), %0d result beats checked,",
                 beats_sent, puts_sent, gets_sent, results_checked);
        $display("peak fill %0d of %0d slots, with a 200-cycle output stall.",
                 peak_level, DEPTH);
        if (fail_count == 0)
            $display("[burst_ring_fifo] OK");
        else
            $display("[burst_ring_fifo] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[burst_ring_fifo] ERROR");
        $finish;
    end

endmodule

>>> burst_ring_fifo.f
rtl/core/brfifo_pkg.sv
rtl/core/brfifo_ram.sv
rtl/core/burst_ring_fifo.sv
rtl/core/brfifo_checker.sv
tb/burst_ring_fifo_checker.sv
tb/burst_ring_fifo_tb.sv
